// File: hw/rtl/phkl_pkg.sv
// Package for the perfect hash key lookup: field widths, codes, config types
// and small helper functions shared by the front end, back end and top level.
// Depends on nothing.
package phkl_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_KEY_LEN_DEF  = 32;
  localparam int unsigned MAX_SET_SIZE_DEF = 256;
  localparam int unsigned MAX_VERTICES_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF    = 16;

  // Fixed field widths of the interface.
  localparam int unsigned INDEX_W   = 13;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned SET_W     = 9;
  localparam int unsigned MOD_W     = 13;
  localparam int unsigned HASH_W    = 12;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 3;

  // Upper bound on both moduli.
  localparam int unsigned RESULT_LIMIT = 4096;

  // Entries in the queue between front end and back end.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Request codes carried in req_type.
  typedef enum logic [1:0] {
    REQ_WR_FIRST  = 2'd0,
    REQ_WR_SECOND = 2'd1,
    REQ_WR_VERTEX = 2'd2,
    REQ_KEY       = 2'd3
  } req_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ENTRIES  = 3'd0,
    CFG_NUM_VERTICES = 3'd1,
    CFG_KEY_LENGTH   = 3'd2,
    CFG_SET_SIZE     = 3'd3,
    CFG_SET_MIN      = 3'd4
  } cfg_idx_e;

  // Kind of a queue entry: finished key sums or a vertex table write.
  typedef enum logic {
    ENT_KEY    = 1'b0,
    ENT_VERTEX = 1'b1
  } entry_kind_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_MOD_UV = 2'd1,
    ST_READ   = 2'd2,
    ST_MOD_T  = 2'd3
  } back_state_e;

  // Registers the front end needs.
  typedef struct packed {
    logic [LEN_W-1:0]  key_length;
    logic [SET_W-1:0]  set_size;
    logic [BYTE_W-1:0] set_min;
  } front_cfg_t;

  // Registers the back end needs.
  typedef struct packed {
    logic [MOD_W-1:0] num_entries;
    logic [MOD_W-1:0] num_vertices;
  } back_cfg_t;

  // Address bits of the vertex table.
  function automatic int unsigned vtx_addr_bits(input int unsigned max_vertices);
    return (max_vertices > 1) ? $clog2(max_vertices) : 1;
  endfunction

  // Width of the shared field of a queue entry (sum or vertex address).
  function automatic int unsigned entry_a_bits(input int unsigned word_bits,
                                               input int unsigned max_vertices);
    int unsigned va;
    va = vtx_addr_bits(max_vertices);
    return (word_bits > va) ? word_bits : va;
  endfunction

  // Queue entry: kind, bad flag, field a, field b.
  function automatic int unsigned entry_bits(input int unsigned word_bits,
                                             input int unsigned max_vertices);
    return 2 + entry_a_bits(word_bits, max_vertices) + word_bits;
  endfunction

  // Force a modulus into the range one to hi.
  function automatic logic [MOD_W-1:0] clamp_mod(input logic [MOD_W-1:0] x,
                                                 input logic [MOD_W-1:0] hi);
    logic [MOD_W-1:0] r;
    if (x == '0) begin
      r = MOD_W'(1);
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/phkl_fifo.sv
// Small first-word-fall-through queue between the hash front end and back end.
// Depends on nothing beyond its parameters.
module phkl_fifo #(
  parameter int unsigned DW    = 34,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DW-1:0]    data_i,
  input  logic             pop_i,
  output logic [DW-1:0]    data_o,
  output logic             empty_o,
  output logic [CNT_W-1:0] cnt_o
);

  logic [DW-1:0]    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  // Storage; entries need no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= CNT_W'(cnt_q + 1'b1);
      end else if (!push_i && pop_i) begin
        cnt_q <= CNT_W'(cnt_q - 1'b1);
      end
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;

  // The front end reserves room before it accepts, so a push never meets a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> (32'(cnt_q) < DEPTH))
    else $error("queue push while full");

  // The back end only pops what is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> (cnt_q != '0))
    else $error("queue pop while empty");

endmodule

// File: hw/rtl/phkl_mod.sv
// Bit-serial remainder unit: one dividend bit per cycle, restoring style.
// Depends on nothing beyond its parameters.
module phkl_mod #(
  parameter int unsigned DW = 17,
  parameter int unsigned MW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [MW-1:0] divisor_i,
  output logic          busy_o,
  output logic [MW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dvd_q;
  logic [MW-1:0] div_q, rem_q;
  logic [MW:0]   trial;
  logic          fits;
  logic [MW-1:0] rem_nx;

  // One step: shift in the next dividend bit and subtract when it fits.
  always_comb begin
    trial  = {rem_q, dvd_q[DW-1]};
    fits   = (trial >= {1'b0, div_q});
    rem_nx = fits ? MW'(trial - {1'b0, div_q}) : MW'(trial);
  end

  // Control: busy from a start until all DW dividend bits have been shifted in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= CW'(cnt_q - 1'b1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      rem_q <= rem_nx;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// File: hw/rtl/phkl_front.sv
// Hash front end: takes request beats, holds the two position tables and
// accumulates the per-key sums into queue entries. Depends on phkl_pkg.
module phkl_front import phkl_pkg::*; #(
  parameter int unsigned MAX_KEY_LEN  = MAX_KEY_LEN_DEF,
  parameter int unsigned MAX_SET_SIZE = MAX_SET_SIZE_DEF,
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned WORD_BITS    = WORD_BITS_DEF,
  localparam int unsigned ENTRY_W = entry_bits(WORD_BITS, MAX_VERTICES),
  localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  front_cfg_t         cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [INDEX_W-1:0] table_index_i,
  input  logic [VALUE_W-1:0] table_value_i,
  input  logic [BYTE_W-1:0]  key_byte_i,
  input  logic [QCNT_W-1:0]  q_cnt_i,
  output logic               q_push_o,
  output logic [ENTRY_W-1:0] q_data_o
);

  localparam int unsigned TABLE_DEPTH = MAX_KEY_LEN * MAX_SET_SIZE;
  localparam int unsigned TA_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned POS_W = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int unsigned LC_W  = LEN_W + 1;
  localparam int unsigned AF_W  = POS_W + SET_W + 1;
  localparam int unsigned VA_W  = vtx_addr_bits(MAX_VERTICES);
  localparam int unsigned A_W   = entry_a_bits(WORD_BITS, MAX_VERTICES);

  req_e                 req;
  logic                 acc;
  logic                 is_key, tbl_in_range, vtx_in_range;
  logic                 wr_first, wr_second;
  logic [TA_W-1:0]      waddr, raddr;
  logic [WORD_BITS-1:0] wval;
  logic [LC_W-1:0]      len_eff, pos_next;
  logic [SET_W-1:0]     ss_eff;
  logic [BYTE_W-1:0]    off;
  logic                 bad_now, last_now;
  logic [AF_W-1:0]      a_full;

  logic [WORD_BITS-1:0] first_mem  [TABLE_DEPTH];
  logic [WORD_BITS-1:0] second_mem [TABLE_DEPTH];
  logic [WORD_BITS-1:0] first_rd_q, second_rd_q;

  logic [POS_W-1:0]     pos_q;
  logic [WORD_BITS-1:0] first_sum_q, second_sum_q;
  logic                 bad_seen_q;

  logic                 s_valid_q, s_last_q, s_bad_q;
  entry_kind_e          s_kind_q;
  logic [VA_W-1:0]      s_vaddr_q;
  logic [WORD_BITS-1:0] s_vval_q;

  logic [WORD_BITS-1:0] sum1_nx, sum2_nx;
  logic                 bad_nx;

  // Request decode and table addressing.
  always_comb begin
    req          = req_e'(req_type_i);
    acc          = in_valid_i && in_ready_o;
    is_key       = (req == REQ_KEY);
    tbl_in_range = (32'(table_index_i) < TABLE_DEPTH);
    vtx_in_range = (32'(table_index_i) < MAX_VERTICES);
    wr_first     = acc && (req == REQ_WR_FIRST) && tbl_in_range;
    wr_second    = acc && (req == REQ_WR_SECOND) && tbl_in_range;
    waddr        = TA_W'(table_index_i);
    wval         = WORD_BITS'(table_value_i);

    // Effective key length and alphabet size.
    if (cfg_i.key_length == '0) begin
      len_eff = LC_W'(1);
    end else if (32'(cfg_i.key_length) > MAX_KEY_LEN) begin
      len_eff = LC_W'(MAX_KEY_LEN);
    end else begin
      len_eff = LC_W'(cfg_i.key_length);
    end
    if (32'(cfg_i.set_size) > MAX_SET_SIZE) begin
      ss_eff = SET_W'(MAX_SET_SIZE);
    end else begin
      ss_eff = cfg_i.set_size;
    end

    // Character class and table address of this byte.
    off      = key_byte_i - cfg_i.set_min;
    bad_now  = (key_byte_i < cfg_i.set_min) || ({1'b0, off} >= ss_eff);
    a_full   = AF_W'(pos_q) * AF_W'(ss_eff) + AF_W'(off);
    raddr    = a_full[TA_W-1:0];
    pos_next = LC_W'(pos_q) + LC_W'(1);
    last_now = (pos_next >= len_eff);
  end

  // Position tables: one write or one read per cycle, read data registered.
  always_ff @(posedge clk_i) begin
    if (wr_first) begin
      first_mem[waddr] <= wval;
    end
    if (wr_second) begin
      second_mem[waddr] <= wval;
    end
    if (acc && is_key) begin
      first_rd_q  <= first_mem[raddr];
      second_rd_q <= second_mem[raddr];
    end
  end

  // Stage after the table read: control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      s_kind_q  <= ENT_KEY;
      s_last_q  <= 1'b0;
      s_bad_q   <= 1'b0;
      pos_q     <= '0;
    end else begin
      s_valid_q <= acc && (is_key || ((req == REQ_WR_VERTEX) && vtx_in_range));
      if (acc) begin
        s_kind_q <= is_key ? ENT_KEY : ENT_VERTEX;
        s_last_q <= last_now;
        s_bad_q  <= bad_now;
      end
      if (acc && is_key) begin
        pos_q <= last_now ? '0 : POS_W'(pos_next);
      end
    end
  end

  // Stage after the table read: vertex write payload.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s_vaddr_q <= VA_W'(table_index_i);
      s_vval_q  <= wval;
    end
  end

  // Sum update; a byte outside the alphabet adds nothing.
  always_comb begin
    sum1_nx = s_bad_q ? first_sum_q  : first_sum_q + first_rd_q;
    sum2_nx = s_bad_q ? second_sum_q : second_sum_q + second_rd_q;
    bad_nx  = bad_seen_q || s_bad_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_sum_q  <= '0;
      second_sum_q <= '0;
      bad_seen_q   <= 1'b0;
    end else if (s_valid_q && (s_kind_q == ENT_KEY)) begin
      if (s_last_q) begin
        first_sum_q  <= '0;
        second_sum_q <= '0;
        bad_seen_q   <= 1'b0;
      end else begin
        first_sum_q  <= sum1_nx;
        second_sum_q <= sum2_nx;
        bad_seen_q   <= bad_nx;
      end
    end
  end

  // Queue entry: the finished key sums or a vertex write, in arrival order.
  always_comb begin
    q_push_o = s_valid_q && ((s_kind_q == ENT_VERTEX) || s_last_q);
    if (s_kind_q == ENT_VERTEX) begin
      q_data_o = {ENT_VERTEX, 1'b0, A_W'(s_vaddr_q), s_vval_q};
    end else begin
      q_data_o = {ENT_KEY, bad_nx, A_W'(sum1_nx), sum2_nx};
    end
  end

  // Accept only while the queue has room for this beat and the one in flight.
  assign in_ready_o = ((QCNT_W + 1)'(q_cnt_i) + (QCNT_W + 1)'(q_push_o))
                      < (QCNT_W + 1)'(QUEUE_DEPTH);

  // The key position never leaves the table rows.
  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(pos_q) < MAX_KEY_LEN)
    else $error("key position beyond the last table row");

endmodule

// File: hw/rtl/phkl_back.sv
// Hash back end: reduces the two sums, looks up the vertex table, reduces the
// total and holds the result beat. Depends on phkl_pkg and phkl_mod.
module phkl_back import phkl_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned WORD_BITS    = WORD_BITS_DEF,
  localparam int unsigned ENTRY_W = entry_bits(WORD_BITS, MAX_VERTICES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  back_cfg_t          cfg_i,
  input  logic [ENTRY_W-1:0] q_data_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [HASH_W-1:0]  hash_index_o,
  output logic               bad_char_o
);

  localparam int unsigned VA_W  = vtx_addr_bits(MAX_VERTICES);
  localparam int unsigned A_W   = entry_a_bits(WORD_BITS, MAX_VERTICES);
  localparam int unsigned DVD_W = WORD_BITS + 1;
  localparam int unsigned VLIM  = (MAX_VERTICES < RESULT_LIMIT) ? MAX_VERTICES : RESULT_LIMIT;

  back_state_e          state_q, state_d;
  entry_kind_e          ent_kind;
  logic                 ent_bad;
  logic [A_W-1:0]       ent_a;
  logic [WORD_BITS-1:0] ent_b;

  logic [MOD_W-1:0]     nv_eff, ne_eff;
  logic                 vtx_we, start_uv, rd_en, start_t, load_out;

  logic                 start_a, busy_a, busy_b;
  logic [DVD_W-1:0]     dvd_a;
  logic [MOD_W-1:0]     div_a, rem_a, rem_b;

  logic [WORD_BITS-1:0] vtx_mem [MAX_VERTICES];
  logic [WORD_BITS-1:0] vu_q, vv_q;
  logic                 bad_q;
  logic                 out_valid_q;
  logic [HASH_W-1:0]    hash_q;
  logic                 bad_out_q;

  // Queue entry fields and effective moduli.
  always_comb begin
    ent_kind = entry_kind_e'(q_data_i[ENTRY_W-1]);
    ent_bad  = q_data_i[ENTRY_W-2];
    ent_a    = q_data_i[WORD_BITS+A_W-1:WORD_BITS];
    ent_b    = q_data_i[WORD_BITS-1:0];
    nv_eff   = clamp_mod(cfg_i.num_vertices, MOD_W'(VLIM));
    ne_eff   = clamp_mod(cfg_i.num_entries, MOD_W'(RESULT_LIMIT));
  end

  // Sequencer: state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer: next state and strobes.
  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    vtx_we   = 1'b0;
    start_uv = 1'b0;
    rd_en    = 1'b0;
    start_t  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (ent_kind == ENT_VERTEX) begin
            vtx_we = 1'b1;
          end else begin
            start_uv = 1'b1;
            state_d  = ST_MOD_UV;
          end
        end
      end
      ST_MOD_UV: begin
        if (!busy_a && !busy_b) begin
          rd_en   = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        start_t = 1'b1;
        state_d = ST_MOD_T;
      end
      ST_MOD_T: begin
        if (!busy_a && (!out_valid_q || out_ready_i)) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Remainder unit A takes the first sum, then the vertex total.
  always_comb begin
    start_a = start_uv || start_t;
    if (start_t) begin
      dvd_a = DVD_W'(vu_q) + DVD_W'(vv_q);
      div_a = ne_eff;
    end else begin
      dvd_a = DVD_W'(ent_a[WORD_BITS-1:0]);
      div_a = nv_eff;
    end
  end

  phkl_mod #(
    .DW (DVD_W),
    .MW (MOD_W)
  ) u_mod_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_a),
    .dividend_i (dvd_a),
    .divisor_i  (div_a),
    .busy_o     (busy_a),
    .rem_o      (rem_a)
  );

  phkl_mod #(
    .DW (DVD_W),
    .MW (MOD_W)
  ) u_mod_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_uv),
    .dividend_i (DVD_W'(ent_b)),
    .divisor_i  (nv_eff),
    .busy_o     (busy_b),
    .rem_o      (rem_b)
  );

  // Vertex table: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (vtx_we) begin
      vtx_mem[VA_W'(ent_a)] <= ent_b;
    end
    if (rd_en) begin
      vu_q <= vtx_mem[VA_W'(rem_a)];
      vv_q <= vtx_mem[VA_W'(rem_b)];
    end
    if (start_uv) begin
      bad_q <= ent_bad;
    end
    if (load_out) begin
      hash_q    <= rem_a[HASH_W-1:0];
      bad_out_q <= bad_q;
    end
  end

  // Result register; the sequencer waits while it is still full.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_index_o = hash_q;
  assign bad_char_o   = bad_out_q;

  // No remainder computation may still be running once the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_IDLE) |-> (!busy_a && !busy_b))
    else $error("remainder unit busy while back end idle");

endmodule

// File: hw/rtl/perfect_hash_key_lookup.sv
// Perfect hash key lookup, top level: configuration registers, front end,
// entry queue and back end. Depends on phkl_pkg and all phkl_* modules.
//
// Table writes and key bytes are taken at one beat per cycle as long as the
// four-entry queue between the front and back end has room. Each key byte
// reads both position tables in the cycle it is accepted and is added into
// the running sums on the next cycle. A completed key, and every vertex table
// write, becomes one queue entry. The back end writes a vertex entry straight
// into the vertex table. For a key, the bit-serial remainder units first
// reduce both sums together, the vertex table is then read on both ports,
// and the total is reduced in turn. Results are held in an output register.
// The tables have no reset or clearing pass; entries must be written before
// a key reads them.
module perfect_hash_key_lookup import phkl_pkg::*; #(
  parameter int unsigned MAX_KEY_LEN  = MAX_KEY_LEN_DEF,
  parameter int unsigned MAX_SET_SIZE = MAX_SET_SIZE_DEF,
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned WORD_BITS    = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [INDEX_W-1:0]   table_index_i,
  input  logic [VALUE_W-1:0]   table_value_i,
  input  logic [BYTE_W-1:0]    key_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [HASH_W-1:0]    hash_index_o,
  output logic                 bad_char_o
);

  localparam int unsigned ENTRY_W = entry_bits(WORD_BITS, MAX_VERTICES);
  localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  logic [MOD_W-1:0]  num_entries_q, num_vertices_q;
  logic [LEN_W-1:0]  key_length_q;
  logic [SET_W-1:0]  set_size_q;
  logic [BYTE_W-1:0] set_min_q;

  front_cfg_t        front_cfg;
  back_cfg_t         back_cfg;

  logic               q_push, q_pop, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;
  logic [QCNT_W-1:0]  q_cnt;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_entries_q  <= MOD_W'(1);
      num_vertices_q <= MOD_W'(1);
      key_length_q   <= LEN_W'(1);
      set_size_q     <= SET_W'(256);
      set_min_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_ENTRIES:  num_entries_q  <= cfg_wdata_i[MOD_W-1:0];
        CFG_NUM_VERTICES: num_vertices_q <= cfg_wdata_i[MOD_W-1:0];
        CFG_KEY_LENGTH:   key_length_q   <= cfg_wdata_i[LEN_W-1:0];
        CFG_SET_SIZE:     set_size_q     <= cfg_wdata_i[SET_W-1:0];
        CFG_SET_MIN:      set_min_q      <= cfg_wdata_i[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    front_cfg.key_length  = key_length_q;
    front_cfg.set_size    = set_size_q;
    front_cfg.set_min     = set_min_q;
    back_cfg.num_entries  = num_entries_q;
    back_cfg.num_vertices = num_vertices_q;
  end

  phkl_front #(
    .MAX_KEY_LEN  (MAX_KEY_LEN),
    .MAX_SET_SIZE (MAX_SET_SIZE),
    .MAX_VERTICES (MAX_VERTICES),
    .WORD_BITS    (WORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (front_cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .key_byte_i    (key_byte_i),
    .q_cnt_i       (q_cnt),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  phkl_fifo #(
    .DW    (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty),
    .cnt_o   (q_cnt)
  );

  phkl_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .WORD_BITS    (WORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (back_cfg),
    .q_data_i     (q_rdata),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_index_o (hash_index_o),
    .bad_char_o   (bad_char_o)
  );

endmodule
